// ===== rtl/line_line_closest_points_macros.svh =====
// ----------------------------------------------------------------------------
// Line-line closest points: assertion macros
// Concurrent checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_CLOSEST_POINTS_MACROS_SVH
`define LINE_LINE_CLOSEST_POINTS_MACROS_SVH

`ifndef SYNTHESIS
`define LLCP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line_line_closest_points: implication check failed");
`define LLCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line_line_closest_points: next-cycle check failed");
`else
`define LLCP_ASSERT_IMPL(label, ante, cons)
`define LLCP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/llcp_pkg.sv =====
// ----------------------------------------------------------------------------
// llcp_pkg
// Widths, payload types and limits shared by the closest-points pipeline.
// ----------------------------------------------------------------------------
package llcp_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int DOT_W       = 2 * DIFF_W + 1;
  localparam int DOT_MAG_W   = DOT_W - 1;
  localparam int NUM_W       = 2 * DOT_W + 1;
  localparam int MAG_W       = NUM_W - 1;
  localparam int PROD_W      = DIFF_W + MAG_W;
  localparam int QUOT_BITS   = 42;
  localparam int OFFSET_BITS = 40;
  localparam int OFF_W       = OFFSET_BITS + 1;
  localparam int MUL_CHUNK   = 32;
  localparam int SUM_W       = (COORD_WIDTH > OFF_W ? COORD_WIDTH : OFF_W) + 2;

  localparam logic signed [SUM_W-1:0] COORD_MAX =
    (SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } line_pair_t;

  typedef struct packed {
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
    coord_t mid_x;
    coord_t mid_y;
    coord_t mid_z;
    logic   found;
  } closest_t;

endpackage

// ===== rtl/llcp_mul.sv =====
// ----------------------------------------------------------------------------
// llcp_mul
// Unsigned multiplier, operands cut into chunks; partial products, then sum.
// Partial products and the sum are each registered, advancing on en.
// ----------------------------------------------------------------------------
module llcp_mul #(
  parameter int A_W = 52,
  parameter int B_W = 52
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);
  import llcp_pkg::*;

  localparam int NA = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PW = (NA + NB) * MUL_CHUNK;

  logic [NA*MUL_CHUNK-1:0] a_ext;
  logic [NB*MUL_CHUNK-1:0] b_ext;
  logic [2*MUL_CHUNK-1:0]  part [NA*NB];
  logic [PW-1:0]           total;

  assign a_ext = (NA*MUL_CHUNK)'(a);
  assign b_ext = (NB*MUL_CHUNK)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          part[i*NB+j] <= (2*MUL_CHUNK)'(a_ext[i*MUL_CHUNK +: MUL_CHUNK])
                        * (2*MUL_CHUNK)'(b_ext[j*MUL_CHUNK +: MUL_CHUNK]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        total = total + (PW'(part[i*NB+j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= total[A_W+B_W-1:0];
    end
  end

endmodule

// ===== rtl/llcp_div.sv =====
// ----------------------------------------------------------------------------
// llcp_div
// Pipelined restoring divider, one quotient bit per stage, rounds half away
// from zero on magnitudes and clamps the result to the offset limit.
// ----------------------------------------------------------------------------
module llcp_div #(
  parameter int N_W = 129,
  parameter int D_W = 104
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [N_W-1:0]            num,
  input  logic [D_W-1:0]            den,
  output logic [llcp_pkg::OFF_W-1:0] quo
);
  import llcp_pkg::*;

  localparam logic [QUOT_BITS:0] LIMIT = (QUOT_BITS+1)'(1) << OFFSET_BITS;

  logic [D_W-1:0]       rem  [QUOT_BITS+1];
  logic [D_W-1:0]       dn   [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] low  [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] qacc [QUOT_BITS+1];
  logic                 ovf  [QUOT_BITS+1];

  logic [N_W-QUOT_BITS-1:0] high;
  logic                     rnd;
  logic [QUOT_BITS:0]       qr;

  assign high = num[N_W-1:QUOT_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      ovf[0]  <= D_W'(high) >= den;
      rem[0]  <= D_W'(high);
      low[0]  <= num[QUOT_BITS-1:0];
      qacc[0] <= '0;
      dn[0]   <= den;
    end
  end

  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    logic [D_W:0] trial;
    logic         ge;

    always_comb begin
      trial = {rem[k], low[k][QUOT_BITS-1]};
      ge    = trial >= {1'b0, dn[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? D_W'(trial - {1'b0, dn[k]}) : trial[D_W-1:0];
        low[k+1]  <= {low[k][QUOT_BITS-2:0], 1'b0};
        qacc[k+1] <= {qacc[k][QUOT_BITS-2:0], ge};
        dn[k+1]   <= dn[k];
        ovf[k+1]  <= ovf[k];
      end
    end
  end

  always_comb begin
    rnd = {rem[QUOT_BITS], 1'b0} >= {1'b0, dn[QUOT_BITS]};
    qr  = (QUOT_BITS+1)'(qacc[QUOT_BITS]) + (QUOT_BITS+1)'(rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= (ovf[QUOT_BITS] || qr > LIMIT) ? LIMIT[OFF_W-1:0] : qr[OFF_W-1:0];
    end
  end

endmodule

// ===== rtl/line_line_closest_points.sv =====
// ----------------------------------------------------------------------------
// line_line_closest_points
// Throughput: one beat per cycle while not stalled.
// The 42-stage divider sets the pipeline depth.
// Reset clears only the valid bits; the whole pipeline freezes on a stall.
// ----------------------------------------------------------------------------
`include "line_line_closest_points_macros.svh"

module line_line_closest_points (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 line_valid,
  output logic                 line_stall,
  input  llcp_pkg::line_pair_t lines,
  output logic                 pts_valid,
  input  logic                 pts_stall,
  output llcp_pkg::closest_t   pts
);
  import llcp_pkg::*;

  localparam int DIV_LAT   = QUOT_BITS + 2;
  localparam int S_DIV_IN  = 10;
  localparam int S_DIV_OUT = S_DIV_IN + DIV_LAT;
  localparam int LAT       = S_DIV_OUT + 2;
  localparam int SIDE_LEN  = S_DIV_OUT;
  localparam int FLAG_LEN  = S_DIV_OUT - 7;
  localparam int E1343 = 0, E4321 = 1, E1321 = 2, E4343 = 3, E2121 = 4;
  localparam int MA_SEL [6] = '{E2121, E4321, E1343, E1321, E1343, E1321};
  localparam int MB_SEL [6] = '{E4343, E4321, E4321, E4343, E2121, E4321};

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef struct packed {
    coord_t [2:0] p1;
    coord_t [2:0] p3;
    diff_t  [2:0] d21;
    diff_t  [2:0] d43;
    logic         zero;
  } side_t;

  typedef struct packed {
    logic       fail;
    logic [2:0] neg_a;
    logic [2:0] neg_b;
  } flag_t;

  function automatic coord_t sat_add(coord_t p, logic [OFF_W-1:0] off, logic neg);
    logic signed [SUM_W-1:0] pe;
    logic signed [SUM_W-1:0] oe;
    logic signed [SUM_W-1:0] s;
    pe = SUM_W'(p);
    oe = signed'(SUM_W'(off));
    s  = neg ? pe - oe : pe + oe;
    if (s > COORD_MAX) s = COORD_MAX;
    if (s < COORD_MIN) s = COORD_MIN;
    return coord_t'(s[COORD_WIDTH-1:0]);
  endfunction

  function automatic coord_t mid_of(coord_t a, coord_t b);
    logic signed [COORD_WIDTH+1:0] m;
    m = (COORD_WIDTH+2)'(a) + (COORD_WIDTH+2)'(b) + (COORD_WIDTH+2)'(1);
    return coord_t'(m[COORD_WIDTH:1]);
  endfunction

  logic                         en;
  logic [LAT-1:0]               vld;
  side_t                        side_dl [SIDE_LEN];
  flag_t                        flag_dl [FLAG_LEN];
  diff_t                        d13 [3];
  diff_t                        d21 [3];
  diff_t                        d43 [3];
  logic signed [2*DIFF_W-1:0]   pr  [5][3];
  logic signed [DOT_W-1:0]      dot [5];
  logic [DOT_MAG_W-1:0]         dmag [5];
  logic [4:0]                   dneg;
  logic [2*DOT_MAG_W-1:0]       mp [6];
  logic [5:0]                   mneg_s5;
  logic [5:0]                   mneg_s6;
  logic signed [NUM_W-1:0]      sp [6];
  logic signed [NUM_W-1:0]      den_s7;
  logic signed [NUM_W-1:0]      na_s7;
  logic signed [NUM_W-1:0]      nb_s7;
  logic [MAG_W-1:0]             den_s8;
  logic [MAG_W-1:0]             den_s9;
  logic [MAG_W-1:0]             den_s10;
  logic [MAG_W-1:0]             na_s8;
  logic [MAG_W-1:0]             nb_s8;
  logic [DIFF_W-1:0]            dma_s8 [3];
  logic [DIFF_W-1:0]            dmb_s8 [3];
  logic [PROD_W-1:0]            tp [6];
  logic [OFF_W-1:0]             off [6];
  coord_t                       qa [3];
  coord_t                       qb [3];
  logic                         fail_s;
  side_t                        s7;
  side_t                        s_end;
  flag_t                        f_end;

  assign en         = !(pts_valid && pts_stall);
  assign line_stall = !en;
  assign pts_valid  = vld[LAT-1];
  assign s7         = side_dl[6];
  assign s_end      = side_dl[SIDE_LEN-1];
  assign f_end      = flag_dl[FLAG_LEN-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], line_valid};
    end
  end

  // differences and side data
  always_ff @(posedge clk) begin
    if (en) begin
      d21[0] <= DIFF_W'(lines.a_end_x) - DIFF_W'(lines.a_start_x);
      d21[1] <= DIFF_W'(lines.a_end_y) - DIFF_W'(lines.a_start_y);
      d21[2] <= DIFF_W'(lines.a_end_z) - DIFF_W'(lines.a_start_z);
      d43[0] <= DIFF_W'(lines.b_end_x) - DIFF_W'(lines.b_start_x);
      d43[1] <= DIFF_W'(lines.b_end_y) - DIFF_W'(lines.b_start_y);
      d43[2] <= DIFF_W'(lines.b_end_z) - DIFF_W'(lines.b_start_z);
      d13[0] <= DIFF_W'(lines.a_start_x) - DIFF_W'(lines.b_start_x);
      d13[1] <= DIFF_W'(lines.a_start_y) - DIFF_W'(lines.b_start_y);
      d13[2] <= DIFF_W'(lines.a_start_z) - DIFF_W'(lines.b_start_z);
      side_dl[0].p1  <= {lines.a_start_z, lines.a_start_y, lines.a_start_x};
      side_dl[0].p3  <= {lines.b_start_z, lines.b_start_y, lines.b_start_x};
      side_dl[0].d21 <= {DIFF_W'(lines.a_end_z) - DIFF_W'(lines.a_start_z),
                         DIFF_W'(lines.a_end_y) - DIFF_W'(lines.a_start_y),
                         DIFF_W'(lines.a_end_x) - DIFF_W'(lines.a_start_x)};
      side_dl[0].d43 <= {DIFF_W'(lines.b_end_z) - DIFF_W'(lines.b_start_z),
                         DIFF_W'(lines.b_end_y) - DIFF_W'(lines.b_start_y),
                         DIFF_W'(lines.b_end_x) - DIFF_W'(lines.b_start_x)};
      side_dl[0].zero <= (lines.a_end_x == lines.a_start_x &&
                          lines.a_end_y == lines.a_start_y &&
                          lines.a_end_z == lines.a_start_z) ||
                         (lines.b_end_x == lines.b_start_x &&
                          lines.b_end_y == lines.b_start_y &&
                          lines.b_end_z == lines.b_start_z);
      for (int k = 1; k < SIDE_LEN; k++) begin
        side_dl[k] <= side_dl[k-1];
      end
    end
  end

  // dot products: products, sums, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr[E1343][i] <= d13[i] * d43[i];
        pr[E4321][i] <= d43[i] * d21[i];
        pr[E1321][i] <= d13[i] * d21[i];
        pr[E4343][i] <= d43[i] * d43[i];
        pr[E2121][i] <= d21[i] * d21[i];
      end
      for (int k = 0; k < 5; k++) begin
        dot[k]  <= DOT_W'(pr[k][0]) + DOT_W'(pr[k][1]) + DOT_W'(pr[k][2]);
        dmag[k] <= dot[k][DOT_W-1] ? DOT_MAG_W'(-dot[k]) : DOT_MAG_W'(dot[k]);
        dneg[k] <= dot[k][DOT_W-1];
      end
    end
  end

  for (genvar j = 0; j < 6; j++) begin : g_mul1
    llcp_mul #(.A_W(DOT_MAG_W), .B_W(DOT_MAG_W)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (dmag[MA_SEL[j]]),
      .b   (dmag[MB_SEL[j]]),
      .p   (mp[j])
    );
  end

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      sp[j] = mneg_s6[j] ? -signed'(NUM_W'(mp[j])) : signed'(NUM_W'(mp[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        mneg_s5[j] <= dneg[MA_SEL[j]] ^ dneg[MB_SEL[j]];
      end
      mneg_s6 <= mneg_s5;
      den_s7  <= sp[0] - sp[1];
      na_s7   <= sp[2] - sp[3];
      nb_s7   <= sp[4] - sp[5];
      den_s8  <= den_s7[MAG_W-1:0];
      na_s8   <= na_s7[NUM_W-1] ? MAG_W'(-na_s7) : MAG_W'(na_s7);
      nb_s8   <= nb_s7[NUM_W-1] ? MAG_W'(-nb_s7) : MAG_W'(nb_s7);
      flag_dl[0].fail <= s7.zero || den_s7[NUM_W-1] || den_s7 == '0;
      for (int i = 0; i < 3; i++) begin
        dma_s8[i] <= s7.d21[i][DIFF_W-1] ? DIFF_W'(-signed'(s7.d21[i]))
                                         : DIFF_W'(s7.d21[i]);
        dmb_s8[i] <= s7.d43[i][DIFF_W-1] ? DIFF_W'(-signed'(s7.d43[i]))
                                         : DIFF_W'(s7.d43[i]);
        flag_dl[0].neg_a[i] <= s7.d21[i][DIFF_W-1] ^ na_s7[NUM_W-1];
        flag_dl[0].neg_b[i] <= s7.d43[i][DIFF_W-1] ^ nb_s7[NUM_W-1];
      end
      for (int k = 1; k < FLAG_LEN; k++) begin
        flag_dl[k] <= flag_dl[k-1];
      end
      den_s9  <= den_s8;
      den_s10 <= den_s9;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    llcp_mul #(.A_W(DIFF_W), .B_W(MAG_W)) u_mul_a (
      .clk (clk),
      .en  (en),
      .a   (dma_s8[i]),
      .b   (na_s8),
      .p   (tp[i])
    );
    llcp_mul #(.A_W(DIFF_W), .B_W(MAG_W)) u_mul_b (
      .clk (clk),
      .en  (en),
      .a   (dmb_s8[i]),
      .b   (nb_s8),
      .p   (tp[3+i])
    );
  end

  for (genvar j = 0; j < 6; j++) begin : g_div
    llcp_div #(.N_W(PROD_W), .D_W(MAG_W)) u_div (
      .clk (clk),
      .en  (en),
      .num (tp[j]),
      .den (den_s10),
      .quo (off[j])
    );
  end

  // saturate, then midpoint and output beat
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qa[i] <= sat_add(s_end.p1[i], off[i], f_end.neg_a[i]);
        qb[i] <= sat_add(s_end.p3[i], off[3+i], f_end.neg_b[i]);
      end
      fail_s <= f_end.fail;
      pts.near_a_x <= fail_s ? '0 : qa[0];
      pts.near_a_y <= fail_s ? '0 : qa[1];
      pts.near_a_z <= fail_s ? '0 : qa[2];
      pts.near_b_x <= fail_s ? '0 : qb[0];
      pts.near_b_y <= fail_s ? '0 : qb[1];
      pts.near_b_z <= fail_s ? '0 : qb[2];
      pts.mid_x    <= fail_s ? '0 : mid_of(qa[0], qb[0]);
      pts.mid_y    <= fail_s ? '0 : mid_of(qa[1], qb[1]);
      pts.mid_z    <= fail_s ? '0 : mid_of(qa[2], qb[2]);
      pts.found    <= !fail_s;
    end
  end

  `LLCP_ASSERT_IMPL(a_fail_zero, pts_valid && !pts.found, pts.near_a_x == '0 && pts.near_b_y == '0 && pts.mid_z == '0)
  `LLCP_ASSERT_IMPL(a_stall_back, pts_valid && pts_stall, line_stall)
  `LLCP_ASSERT_NEXT(a_freeze, pts_valid && pts_stall && !rst, vld == $past(vld))
  `LLCP_ASSERT_IMPL(a_mid_between, pts_valid && pts.found, pts.near_a_x <= pts.mid_x || pts.near_b_x <= pts.mid_x)

endmodule
